[rtl/etd_pkg.sv]
`timescale 1ns / 1ps
// Shared types and defaults for the Euler totient trial-division unit.
// No dependencies; imported by etd_divider and the top level.
package etd_pkg;

    // Default width of the value and totient fields
    localparam int VALUE_BITS_DEF = 31;

    // Sequencer states of the top level
    typedef enum logic [3:0] {
        S_IDLE,
        S_TRY_GO,
        S_TRY_WAIT,
        S_PHI_GO,
        S_PHI_WAIT,
        S_STRIP_GO,
        S_STRIP_WAIT,
        S_LAST_GO,
        S_LAST_WAIT,
        S_OUT
    } state_t;

endpackage

[rtl/etd_divider.sv]
`timescale 1ns / 1ps
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on etd_pkg for the default width.
module etd_divider #(
    parameter int W = etd_pkg::VALUE_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);
    import etd_pkg::*;

    localparam int CNT_BITS = (W > 1) ? $clog2(W) : 1;
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(W - 1);

    logic                active_reg, active_next;
    logic                done_reg, done_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [W-1:0]        quo_reg, quo_next;
    logic [W-1:0]        rem_reg, rem_next;
    logic [W-1:0]        dvs_reg, dvs_next;
    logic [W:0]          shifted;
    logic                fits;

    // Bring down the next dividend bit and try one subtraction
    assign shifted = {rem_reg, quo_reg[W-1]};
    assign fits    = (shifted >= {1'b0, dvs_reg});

    always_comb
    begin
        active_next = active_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        dvs_next    = dvs_reg;
        if (start)
        begin
            // Load operands, clear the partial remainder
            active_next = 1'b1;
            cnt_next    = '0;
            quo_next    = dividend;
            rem_next    = '0;
            dvs_next    = divisor;
        end
        else if (active_reg)
        begin
            // Advance one quotient bit
            rem_next = fits ? W'(shifted - {1'b0, dvs_reg}) : shifted[W-1:0];
            quo_next = {quo_reg[W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Shift registers, no reset needed
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

[rtl/euler_totient_trial_division_unit.sv]
`timescale 1ns / 1ps
// Euler totient by trial division by 2 and then odd divisors, built on one bit-serial divider.
// One request at a time: busy high from accept until the done strobe cycle.
// Reset (rst_n low, asynchronous) returns to idle; the strobe cannot be stalled.
module euler_totient_trial_division_unit #(
    parameter int VALUE_BITS = etd_pkg::VALUE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] value,
    output logic                  busy,
    output logic                  done,
    output logic [VALUE_BITS-1:0] totient
);
    import etd_pkg::*;

    state_t                state_reg, state_next;
    logic [VALUE_BITS-1:0] rest_reg, rest_next;
    logic [VALUE_BITS-1:0] result_reg, result_next;
    logic [VALUE_BITS-1:0] d_reg, d_next;
    logic [VALUE_BITS-1:0] d_step;

    logic                  div_start;
    logic [VALUE_BITS-1:0] div_dividend;
    logic [VALUE_BITS-1:0] div_divisor;
    logic                  div_done;
    logic [VALUE_BITS-1:0] div_quo;
    logic [VALUE_BITS-1:0] div_rem;

    logic                  rest_gt_one;
    logic                  rest_is_one;
    logic                  rem_zero;
    logic                  past_root;

    etd_divider #(
        .W (VALUE_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Status flags; d > rest/d is the same test as d*d > rest
    assign rest_is_one = (rest_reg == VALUE_BITS'(1));
    assign rest_gt_one = (rest_reg > VALUE_BITS'(1));
    assign rem_zero    = (div_rem == '0);
    assign past_root   = (d_reg > div_quo);
    // Step to the next candidate: 2 then odd numbers only
    assign d_step      = (d_reg == VALUE_BITS'(2)) ? VALUE_BITS'(3) : d_reg + VALUE_BITS'(2);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                    state_next = (value == '0) ? S_OUT : S_TRY_GO;
            end
            S_TRY_GO:     state_next = S_TRY_WAIT;
            S_TRY_WAIT:
            begin
                if (div_done)
                begin
                    if (past_root)
                        state_next = rest_gt_one ? S_LAST_GO : S_OUT;
                    else if (rem_zero)
                        state_next = S_PHI_GO;
                    else
                        state_next = S_TRY_GO;
                end
            end
            S_PHI_GO:     state_next = S_PHI_WAIT;
            S_PHI_WAIT:
            begin
                if (div_done)
                    state_next = S_STRIP_GO;
            end
            S_STRIP_GO:   state_next = S_STRIP_WAIT;
            S_STRIP_WAIT:
            begin
                if (div_done)
                begin
                    if (rem_zero)
                        state_next = S_STRIP_GO;
                    else if (rest_is_one)
                        state_next = S_OUT;
                    else
                        state_next = S_TRY_GO;
                end
            end
            S_LAST_GO:    state_next = S_LAST_WAIT;
            S_LAST_WAIT:
            begin
                if (div_done)
                    state_next = S_OUT;
            end
            S_OUT:        state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    // Outputs and divider issue
    always_comb
    begin
        busy         = (state_reg != S_IDLE);
        done         = (state_reg == S_OUT);
        div_start    = 1'b0;
        div_dividend = rest_reg;
        div_divisor  = d_reg;
        case (state_reg)
            S_TRY_GO, S_STRIP_GO:
            begin
                div_start = 1'b1;
            end
            S_PHI_GO:
            begin
                div_start    = 1'b1;
                div_dividend = result_reg;
            end
            S_LAST_GO:
            begin
                div_start    = 1'b1;
                div_dividend = result_reg;
                div_divisor  = rest_reg;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    // Datapath updates
    always_comb
    begin
        rest_next   = rest_reg;
        result_next = result_reg;
        d_next      = d_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    rest_next   = value;
                    result_next = value;
                    d_next      = VALUE_BITS'(2);
                end
            end
            S_TRY_WAIT:
            begin
                if (div_done && !past_root)
                begin
                    if (rem_zero)
                        rest_next = div_quo;
                    else
                        d_next = d_step;
                end
            end
            S_PHI_WAIT, S_LAST_WAIT:
            begin
                if (div_done)
                    result_next = result_reg - div_quo;
            end
            S_STRIP_WAIT:
            begin
                if (div_done)
                begin
                    if (rem_zero)
                        rest_next = div_quo;
                    else
                        d_next = d_step;
                end
            end
            default:
            begin
                d_next = d_reg;
            end
        endcase
    end

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Working values
    always_ff @(posedge clk)
    begin
        rest_reg   <= rest_next;
        result_reg <= result_next;
        d_reg      <= d_next;
    end

    assign totient = result_reg;

    // A divide finishes only while the sequencer waits for one
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_TRY_WAIT || state_reg == S_PHI_WAIT ||
                      state_reg == S_STRIP_WAIT || state_reg == S_LAST_WAIT))
        else $error("divider finished outside a wait state");

    // An accepted request holds the unit busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    // The done strobe lasts one cycle and frees the unit
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done && !busy))
        else $error("done strobe not followed by idle");

    // The trial divisor is never below two when a trial divide is issued
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TRY_GO) |-> (d_reg >= VALUE_BITS'(2)))
        else $error("trial divisor below two");

endmodule
